// File: hw/rtl/tlic_pkg.sv
// shared types for the track line intercept classifier
package tlic_pkg;

    typedef enum logic [1:0] {
        PLACE_BETWEEN = 2'd0,
        PLACE_BEFORE  = 2'd1,
        PLACE_BEYOND  = 2'd2
    } place_t;

endpackage

// File: hw/rtl/tlic_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage, saturating quotient
module tlic_div
    import tlic_pkg::*;
#(
    parameter int NUM_W = 65,
    parameter int DEN_W = 44,
    parameter int QUO_W = 21,
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld_in,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             vld_out,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    localparam int MW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic             vld_reg [0:QUO_W];
    logic [TAG_W-1:0] tag_reg [0:QUO_W];
    logic [MW-1:0]    rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];
    logic             vld_out_reg;
    logic [TAG_W-1:0] tag_out_reg;
    logic [QUO_W-1:0] quo_out_reg;
    logic             ovf_next;

    // quotient too large for the result width: saturate at the end
    assign ovf_next = MW'(num) >= (MW'(den) << QUO_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            tag_reg[0] <= '0;
        end
        else
        begin
            vld_reg[0] <= vld_in;
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= MW'(num);
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        ovf_reg[0] <= ovf_next;
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic [MW-1:0] shifted;
        logic          ge;

        assign shifted = MW'(den_reg[s]) << (QUO_W - 1 - s);
        assign ge      = rem_reg[s] >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
                tag_reg[s+1] <= '0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= ge ? rem_reg[s] - shifted : rem_reg[s];
            den_reg[s+1] <= den_reg[s];
            quo_reg[s+1] <= {quo_reg[s][QUO_W-2:0], ge};
            ovf_reg[s+1] <= ovf_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
            tag_out_reg <= '0;
        end
        else
        begin
            vld_out_reg <= vld_reg[QUO_W];
            tag_out_reg <= tag_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_out_reg <= ovf_reg[QUO_W] ? '1 : quo_reg[QUO_W];
    end

    assign vld_out = vld_out_reg;
    assign tag_out = tag_out_reg;
    assign quo     = quo_out_reg;

endmodule

// File: hw/rtl/tlic_sqrt.sv
// pipelined integer square root, one root bit per stage, rounded to nearest
module tlic_sqrt
    import tlic_pkg::*;
#(
    parameter int ROOT_W = 21,
    parameter int TAG_W  = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld_in,
    input  logic [2*ROOT_W-1:0] sq,
    input  logic [TAG_W-1:0]    tag_in,
    output logic                vld_out,
    output logic [ROOT_W:0]     root,
    output logic [TAG_W-1:0]    tag_out
);

    localparam int RW = ROOT_W + 2;

    logic                vld_reg [0:ROOT_W];
    logic [TAG_W-1:0]    tag_reg [0:ROOT_W];
    logic [2*ROOT_W-1:0] op_reg  [0:ROOT_W];
    logic [RW-1:0]       rem_reg [0:ROOT_W];
    logic [ROOT_W-1:0]   rt_reg  [0:ROOT_W];
    logic                vld_out_reg;
    logic [TAG_W-1:0]    tag_out_reg;
    logic [ROOT_W:0]     root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            tag_reg[0] <= '0;
        end
        else
        begin
            vld_reg[0] <= vld_in;
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg[0]  <= sq;
        rem_reg[0] <= '0;
        rt_reg[0]  <= '0;
    end

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        logic [RW+1:0] cand;
        logic [RW+1:0] trial;
        logic          ge;

        assign cand  = {rem_reg[s], op_reg[s][2*(ROOT_W-1-s)+1 -: 2]};
        assign trial = (RW+2)'({rt_reg[s], 2'b01});
        assign ge    = cand >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
                tag_reg[s+1] <= '0;
            end
            else
            begin
                vld_reg[s+1] <= vld_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            op_reg[s+1]  <= op_reg[s];
            rem_reg[s+1] <= RW'(ge ? cand - trial : cand);
            rt_reg[s+1]  <= {rt_reg[s][ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
            tag_out_reg <= '0;
        end
        else
        begin
            vld_out_reg <= vld_reg[ROOT_W];
            tag_out_reg <= tag_reg[ROOT_W];
        end
    end

    // remainder above the root means the true root is past the half point
    always_ff @(posedge clk)
    begin
        root_reg <= {1'b0, rt_reg[ROOT_W]}
                  + (ROOT_W+1)'(rem_reg[ROOT_W] > RW'(rt_reg[ROOT_W]));
    end

    assign vld_out = vld_out_reg;
    assign tag_out = tag_out_reg;
    assign root    = root_reg;

endmodule

// File: hw/rtl/track_line_intercept_classifier.sv
// top level: line crossing of two track segments, placement and path distances
//
// usage: drive the eight endpoint coordinates and raise start for one cycle
// per request. busy is always low, so a new request may follow in every
// cycle and any number of requests may be in flight.
// each request gives exactly one result: done is high for one cycle and
// found, cross_x, cross_y, place_a, place_b, path_a and path_b are valid in
// that cycle only. the receiver cannot stall, so nothing is held back.
// throughput is one request per cycle. the pipeline includes the quotient
// pipeline (one bit a stage, COORD_BITS+1 stages) and the square root
// pipeline (COORD_BITS+1 stages).
// parallel lines give found low and all other fields zero.
// reset clears every valid bit in flight; requests under way are dropped.
module track_line_intercept_classifier
    import tlic_pkg::*;
#(
    parameter int COORD_BITS = 20
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_first_x,
    input  logic signed [COORD_BITS-1:0] a_first_y,
    input  logic signed [COORD_BITS-1:0] a_last_x,
    input  logic signed [COORD_BITS-1:0] a_last_y,
    input  logic signed [COORD_BITS-1:0] b_first_x,
    input  logic signed [COORD_BITS-1:0] b_first_y,
    input  logic signed [COORD_BITS-1:0] b_last_x,
    input  logic signed [COORD_BITS-1:0] b_last_y,
    output logic                         done,
    output logic                         found,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y,
    output logic [1:0]                   place_a,
    output logic [1:0]                   place_b,
    output logic signed [COORD_BITS-1:0] path_a,
    output logic signed [COORD_BITS-1:0] path_b
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int MW  = 2 * C + 2;
    localparam int NW  = 2 * C + 3;
    localparam int LOW = C + 2;
    localparam int HIW = NW - LOW;
    localparam int LPW = LOW + 1 + DW;
    localparam int HPW = HIW + DW;
    localparam int PW  = 3 * C + 4;
    localparam int NNW = PW + 1;
    localparam int NDW = NW + 1;
    localparam int QB  = C + 1;
    localparam int R   = C + 1;

    typedef struct packed {
        logic signed [C-1:0] fax;
        logic signed [C-1:0] fay;
        logic signed [C-1:0] lax;
        logic signed [C-1:0] lay;
        logic signed [C-1:0] fbx;
        logic signed [C-1:0] fby;
        logic signed [C-1:0] lbx;
        logic signed [C-1:0] lby;
    } pts_t;

    localparam int PTW = $bits(pts_t);

    function automatic logic [C-1:0] sat_c4(input logic [C+3:0] v);
        logic fits;
        fits = (&v[C+3:C-1]) | ~(|v[C+3:C-1]);
        if (fits)
            return v[C-1:0];
        else
            return v[C+3] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    endfunction

    assign busy = 1'b0;

    // stage 1: differences
    logic                 v1_reg;
    pts_t                 pts1_reg;
    logic signed [DW-1:0] dax1_reg, day1_reg, dbx1_reg, dby1_reg, ex1_reg, ey1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        pts1_reg <= '{a_first_x, a_first_y, a_last_x, a_last_y,
                      b_first_x, b_first_y, b_last_x, b_last_y};
        dax1_reg <= DW'(a_last_x) - DW'(a_first_x);
        day1_reg <= DW'(a_last_y) - DW'(a_first_y);
        dbx1_reg <= DW'(b_last_x) - DW'(b_first_x);
        dby1_reg <= DW'(b_last_y) - DW'(b_first_y);
        ex1_reg  <= DW'(b_first_x) - DW'(a_first_x);
        ey1_reg  <= DW'(b_first_y) - DW'(a_first_y);
    end

    // stage 2: cross product terms
    logic                 v2_reg;
    pts_t                 pts2_reg;
    logic signed [DW-1:0] dax2_reg, day2_reg;
    logic signed [MW-1:0] pd1_reg, pd2_reg, pn1_reg, pn2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        pts2_reg <= pts1_reg;
        dax2_reg <= dax1_reg;
        day2_reg <= day1_reg;
        pd1_reg  <= MW'(dax1_reg) * MW'(dby1_reg);
        pd2_reg  <= MW'(day1_reg) * MW'(dbx1_reg);
        pn1_reg  <= MW'(ex1_reg) * MW'(dby1_reg);
        pn2_reg  <= MW'(ey1_reg) * MW'(dbx1_reg);
    end

    // stage 3: denominator and numerator
    logic                 v3_reg;
    pts_t                 pts3_reg;
    logic signed [DW-1:0] dax3_reg, day3_reg;
    logic signed [NW-1:0] den3_reg, num3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        pts3_reg <= pts2_reg;
        dax3_reg <= dax2_reg;
        day3_reg <= day2_reg;
        den3_reg <= NW'(pd1_reg) - NW'(pd2_reg);
        num3_reg <= NW'(pn1_reg) - NW'(pn2_reg);
    end

    // stage 4: numerator times direction, split in two partial products
    logic                  v4_reg;
    pts_t                  pts4_reg;
    logic signed [NW-1:0]  den4_reg;
    logic                  found4_reg;
    logic signed [LPW-1:0] pxl4_reg, pyl4_reg;
    logic signed [HPW-1:0] pxh4_reg, pyh4_reg;
    logic signed [LOW:0]   num_lo;
    logic signed [HIW-1:0] num_hi;

    assign num_lo = $signed({1'b0, num3_reg[LOW-1:0]});
    assign num_hi = $signed(num3_reg[NW-1:LOW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        pts4_reg   <= pts3_reg;
        den4_reg   <= den3_reg;
        found4_reg <= den3_reg != '0;
        pxl4_reg   <= LPW'(num_lo) * LPW'(dax3_reg);
        pyl4_reg   <= LPW'(num_lo) * LPW'(day3_reg);
        pxh4_reg   <= HPW'(num_hi) * HPW'(dax3_reg);
        pyh4_reg   <= HPW'(num_hi) * HPW'(day3_reg);
    end

    // stage 5: combine partial products
    logic                 v5_reg;
    pts_t                 pts5_reg;
    logic signed [NW-1:0] den5_reg;
    logic                 found5_reg;
    logic signed [PW-1:0] px5_reg, py5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        pts5_reg   <= pts4_reg;
        den5_reg   <= den4_reg;
        found5_reg <= found4_reg;
        px5_reg    <= (PW'(pxh4_reg) <<< LOW) + PW'(pxl4_reg);
        py5_reg    <= (PW'(pyh4_reg) <<< LOW) + PW'(pyl4_reg);
    end

    // stage 6: magnitudes and rounding offset for the divider
    logic             v6_reg;
    pts_t             pts6_reg;
    logic             found6_reg, negx6_reg, negy6_reg;
    logic [NNW-1:0]   nx6_reg, ny6_reg;
    logic [NDW-1:0]   d6_reg;
    logic [PW-1:0]    absx, absy;
    logic [NW-1:0]    absd;

    assign absx = px5_reg[PW-1] ? ~px5_reg + 1'b1 : px5_reg;
    assign absy = py5_reg[PW-1] ? ~py5_reg + 1'b1 : py5_reg;
    assign absd = den5_reg[NW-1] ? ~den5_reg + 1'b1 : den5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        pts6_reg   <= pts5_reg;
        found6_reg <= found5_reg;
        negx6_reg  <= px5_reg[PW-1] ^ den5_reg[NW-1];
        negy6_reg  <= py5_reg[PW-1] ^ den5_reg[NW-1];
        nx6_reg    <= {absx, 1'b0} + NNW'(absd);
        ny6_reg    <= {absy, 1'b0} + NNW'(absd);
        d6_reg     <= {absd, 1'b0};
    end

    // quotients
    logic              vdx;
    logic [QB-1:0]     qx, qy;
    logic [PTW+1:0]    tagx;
    logic              negy_d;

    tlic_div #(
        .NUM_W (NNW),
        .DEN_W (NDW),
        .QUO_W (QB),
        .TAG_W (PTW + 2)
    ) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v6_reg),
        .num     (nx6_reg),
        .den     (d6_reg),
        .tag_in  ({found6_reg, negx6_reg, pts6_reg}),
        .vld_out (vdx),
        .quo     (qx),
        .tag_out (tagx)
    );

    tlic_div #(
        .NUM_W (NNW),
        .DEN_W (NDW),
        .QUO_W (QB),
        .TAG_W (1)
    ) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v6_reg),
        .num     (ny6_reg),
        .den     (d6_reg),
        .tag_in  (negy6_reg),
        .vld_out (),
        .quo     (qy),
        .tag_out (negy_d)
    );

    // stage 7: crossing point
    logic                v7_reg;
    logic                found7_reg;
    pts_t                pts7_reg;
    logic signed [C-1:0] ix7_reg, iy7_reg;
    pts_t                ptsd;
    logic [QB:0]         sqx, sqy;

    assign ptsd = pts_t'(tagx[PTW-1:0]);
    assign sqx  = tagx[PTW] ? ~{1'b0, qx} + 1'b1 : {1'b0, qx};
    assign sqy  = negy_d ? ~{1'b0, qy} + 1'b1 : {1'b0, qy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else
            v7_reg <= vdx;
    end

    // the sum is kept wide enough that a saturated quotient cannot wrap it
    always_ff @(posedge clk)
    begin
        found7_reg <= tagx[PTW+1];
        pts7_reg   <= ptsd;
        ix7_reg    <= sat_c4((C+4)'(ptsd.fax) + (C+4)'($signed(sqx)));
        iy7_reg    <= sat_c4((C+4)'(ptsd.fay) + (C+4)'($signed(sqy)));
    end

    // stage 8: vectors from the endpoints to the crossing, index 0 is A
    logic                 v8_reg;
    logic                 found8_reg;
    logic signed [C-1:0]  ix8_reg, iy8_reg;
    logic signed [DW-1:0] fix8_reg [2];
    logic signed [DW-1:0] fiy8_reg [2];
    logic signed [DW-1:0] lix8_reg [2];
    logic signed [DW-1:0] liy8_reg [2];
    logic signed [DW-1:0] dx8_reg  [2];
    logic signed [DW-1:0] dy8_reg  [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        found8_reg  <= found7_reg;
        ix8_reg     <= ix7_reg;
        iy8_reg     <= iy7_reg;
        fix8_reg[0] <= DW'(ix7_reg) - DW'(pts7_reg.fax);
        fiy8_reg[0] <= DW'(iy7_reg) - DW'(pts7_reg.fay);
        lix8_reg[0] <= DW'(ix7_reg) - DW'(pts7_reg.lax);
        liy8_reg[0] <= DW'(iy7_reg) - DW'(pts7_reg.lay);
        dx8_reg[0]  <= DW'(pts7_reg.lax) - DW'(pts7_reg.fax);
        dy8_reg[0]  <= DW'(pts7_reg.lay) - DW'(pts7_reg.fay);
        fix8_reg[1] <= DW'(ix7_reg) - DW'(pts7_reg.fbx);
        fiy8_reg[1] <= DW'(iy7_reg) - DW'(pts7_reg.fby);
        lix8_reg[1] <= DW'(ix7_reg) - DW'(pts7_reg.lbx);
        liy8_reg[1] <= DW'(iy7_reg) - DW'(pts7_reg.lby);
        dx8_reg[1]  <= DW'(pts7_reg.lbx) - DW'(pts7_reg.fbx);
        dy8_reg[1]  <= DW'(pts7_reg.lby) - DW'(pts7_reg.fby);
    end

    // stage 9: dot product terms and squares
    logic                 v9_reg;
    logic                 found9_reg;
    logic signed [C-1:0]  ix9_reg, iy9_reg;
    logic signed [MW-1:0] mflx9_reg [2];
    logic signed [MW-1:0] mfly9_reg [2];
    logic signed [MW-1:0] mfdx9_reg [2];
    logic signed [MW-1:0] mfdy9_reg [2];
    logic signed [MW-1:0] sfx9_reg  [2];
    logic signed [MW-1:0] sfy9_reg  [2];
    logic signed [MW-1:0] sdx9_reg  [2];
    logic signed [MW-1:0] sdy9_reg  [2];
    logic signed [MW-1:0] slx9_reg  [2];
    logic signed [MW-1:0] sly9_reg  [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else
            v9_reg <= v8_reg;
    end

    always_ff @(posedge clk)
    begin
        found9_reg <= found8_reg;
        ix9_reg    <= ix8_reg;
        iy9_reg    <= iy8_reg;
        for (int k = 0; k < 2; k++)
        begin
            mflx9_reg[k] <= MW'(fix8_reg[k]) * MW'(lix8_reg[k]);
            mfly9_reg[k] <= MW'(fiy8_reg[k]) * MW'(liy8_reg[k]);
            mfdx9_reg[k] <= MW'(fix8_reg[k]) * MW'(dx8_reg[k]);
            mfdy9_reg[k] <= MW'(fiy8_reg[k]) * MW'(dy8_reg[k]);
            sfx9_reg[k]  <= MW'(fix8_reg[k]) * MW'(fix8_reg[k]);
            sfy9_reg[k]  <= MW'(fiy8_reg[k]) * MW'(fiy8_reg[k]);
            sdx9_reg[k]  <= MW'(dx8_reg[k]) * MW'(dx8_reg[k]);
            sdy9_reg[k]  <= MW'(dy8_reg[k]) * MW'(dy8_reg[k]);
            slx9_reg[k]  <= MW'(lix8_reg[k]) * MW'(lix8_reg[k]);
            sly9_reg[k]  <= MW'(liy8_reg[k]) * MW'(liy8_reg[k]);
        end
    end

    // stage 10: placement and square root operands
    logic                 v10_reg;
    logic                 found10_reg;
    logic signed [C-1:0]  ix10_reg, iy10_reg;
    place_t               place10_reg [2];
    logic [MW-1:0]        sq1_10_reg  [2];
    logic [MW-1:0]        sq2_10_reg  [2];
    logic signed [NW-1:0] dot_fl      [2];
    logic signed [NW-1:0] dot_fd      [2];
    place_t               place_next  [2];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            dot_fl[k] = NW'(mflx9_reg[k]) + NW'(mfly9_reg[k]);
            dot_fd[k] = NW'(mfdx9_reg[k]) + NW'(mfdy9_reg[k]);
            priority if (dot_fl[k][NW-1])
                place_next[k] = PLACE_BETWEEN;
            else if (dot_fd[k][NW-1] || dot_fd[k] == '0)
                place_next[k] = PLACE_BEFORE;
            else
                place_next[k] = PLACE_BEYOND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10_reg <= 1'b0;
        else
            v10_reg <= v9_reg;
    end

    always_ff @(posedge clk)
    begin
        found10_reg <= found9_reg;
        ix10_reg    <= ix9_reg;
        iy10_reg    <= iy9_reg;
        for (int k = 0; k < 2; k++)
        begin
            place10_reg[k] <= place_next[k];
            // beyond the last point the path is the segment length plus overshoot
            sq1_10_reg[k]  <= (place_next[k] == PLACE_BEYOND)
                            ? $unsigned(sdx9_reg[k]) + $unsigned(sdy9_reg[k])
                            : $unsigned(sfx9_reg[k]) + $unsigned(sfy9_reg[k]);
            sq2_10_reg[k]  <= $unsigned(slx9_reg[k]) + $unsigned(sly9_reg[k]);
        end
    end

    // square roots
    logic              vsq;
    logic [R:0]        ra1, ra2, rb1, rb2;
    logic [2*C-1:0]    tag_pt;
    logic [1:0]        tag_pa, tag_pb;
    logic              tag_found;

    tlic_sqrt #(.ROOT_W(R), .TAG_W(2 * C)) u_sqrt_a1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v10_reg),
        .sq      (sq1_10_reg[0]),
        .tag_in  ({ix10_reg, iy10_reg}),
        .vld_out (vsq),
        .root    (ra1),
        .tag_out (tag_pt)
    );

    tlic_sqrt #(.ROOT_W(R), .TAG_W(2)) u_sqrt_a2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v10_reg),
        .sq      (sq2_10_reg[0]),
        .tag_in  (place10_reg[0]),
        .vld_out (),
        .root    (ra2),
        .tag_out (tag_pa)
    );

    tlic_sqrt #(.ROOT_W(R), .TAG_W(2)) u_sqrt_b1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v10_reg),
        .sq      (sq1_10_reg[1]),
        .tag_in  (place10_reg[1]),
        .vld_out (),
        .root    (rb1),
        .tag_out (tag_pb)
    );

    tlic_sqrt #(.ROOT_W(R), .TAG_W(1)) u_sqrt_b2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (v10_reg),
        .sq      (sq2_10_reg[1]),
        .tag_in  (found10_reg),
        .vld_out (),
        .root    (rb2),
        .tag_out (tag_found)
    );

    // stage 11: path distances and output register
    logic [C+3:0]        path_a_full, path_b_full;
    logic                done_reg, found_reg;
    logic signed [C-1:0] cross_x_reg, cross_y_reg, path_a_reg, path_b_reg;
    logic [1:0]          place_a_reg, place_b_reg;

    always_comb
    begin
        unique case (place_t'(tag_pa))
            PLACE_BETWEEN: path_a_full = (C+4)'(ra1);
            PLACE_BEFORE:  path_a_full = ~(C+4)'(ra1) + 1'b1;
            PLACE_BEYOND:  path_a_full = (C+4)'(ra1) + (C+4)'(ra2);
            default:       path_a_full = '0;
        endcase
        unique case (place_t'(tag_pb))
            PLACE_BETWEEN: path_b_full = (C+4)'(rb1);
            PLACE_BEFORE:  path_b_full = ~(C+4)'(rb1) + 1'b1;
            PLACE_BEYOND:  path_b_full = (C+4)'(rb1) + (C+4)'(rb2);
            default:       path_b_full = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vsq;
    end

    // parallel lines: every field zero
    always_ff @(posedge clk)
    begin
        found_reg   <= tag_found;
        cross_x_reg <= tag_found ? tag_pt[2*C-1:C] : '0;
        cross_y_reg <= tag_found ? tag_pt[C-1:0] : '0;
        place_a_reg <= tag_found ? tag_pa : PLACE_BETWEEN;
        place_b_reg <= tag_found ? tag_pb : PLACE_BETWEEN;
        path_a_reg  <= tag_found ? sat_c4(path_a_full) : '0;
        path_b_reg  <= tag_found ? sat_c4(path_b_full) : '0;
    end

    assign done    = done_reg;
    assign found   = found_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;
    assign place_a = place_a_reg;
    assign place_b = place_b_reg;
    assign path_a  = path_a_reg;
    assign path_b  = path_b_reg;

endmodule

// File: sim/tb_track_line_intercept_classifier.sv
// testbench for the track line intercept classifier: random and directed segment pairs
module tb_track_line_intercept_classifier
    import tlic_pkg::*;
();

    localparam int CB = 20;
    localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam int CSPAN = int'(CMAX);
    localparam int LATENCY = 2 * CB + 17;
    localparam longint CYCLE_LIMIT = 600000;
    localparam int RANDOM_PAIRS = 1650;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct {
        logic   found;
        coord_t x, y;
        place_t pa, pb;
        coord_t da, db;
    } intercept_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    coord_t a_first_x = '0, a_first_y = '0, a_last_x = '0, a_last_y = '0;
    coord_t b_first_x = '0, b_first_y = '0, b_last_x = '0, b_last_y = '0;
    logic done, found;
    coord_t cross_x, cross_y, path_a, path_b;
    logic [1:0] place_a, place_b;

    seg_pair_t  pending[$];
    intercept_t expected_hits[$];
    seg_pair_t  in_flight;
    int gap = 0;
    int mismatches = 0;
    int n_sent = 0, n_checked = 0, n_found = 0;
    int n_place[3] = '{0, 0, 0};
    longint cycles = 0;

    track_line_intercept_classifier dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_first_x(a_first_x), .a_first_y(a_first_y),
        .a_last_x(a_last_x), .a_last_y(a_last_y),
        .b_first_x(b_first_x), .b_first_y(b_first_y),
        .b_last_x(b_last_x), .b_last_y(b_last_y),
        .done(done), .found(found), .cross_x(cross_x), .cross_y(cross_y),
        .place_a(place_a), .place_b(place_b), .path_a(path_a), .path_b(path_b)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic longint clamp(longint v);
        return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
    endfunction

    // length rounded to nearest
    function automatic longint length_of(longint x, longint y);
        logic [127:0] n, c, r;
        n = 128'(x * x + y * y);
        r = 0;
        for (int b = 40; b >= 0; b--)
        begin
            c = r | (128'(1) << b);
            if (c * c <= n)
                r = c;
        end
        if (n - r * r > r)
            r = r + 1;
        return longint'(r);
    endfunction

    function automatic void place_on(longint fx, longint fy, longint lx, longint ly,
                                     longint ix, longint iy,
                                     output place_t pl, output coord_t path_len);
        longint fix, fiy, lix, liy, dx, dy, d;
        fix = ix - fx; fiy = iy - fy;
        lix = ix - lx; liy = iy - ly;
        dx = lx - fx;  dy = ly - fy;
        if (fix * lix + fiy * liy < 0)
        begin
            pl = PLACE_BETWEEN;
            d = length_of(fix, fiy);
        end
        else if (fix * dx + fiy * dy <= 0)
        begin
            pl = PLACE_BEFORE;
            d = -length_of(fix, fiy);
        end
        else
        begin
            pl = PLACE_BEYOND;
            d = length_of(dx, dy) + length_of(lix, liy);
        end
        path_len = coord_t'(clamp(d));
    endfunction

    // quotient rounded to nearest, ties away from zero
    function automatic logic signed [127:0] div_round(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic signed [127:0] an, ad, q;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint sat_wide(logic signed [127:0] v);
        if (v < CMIN) return CMIN;
        if (v > CMAX) return CMAX;
        return longint'(v);
    endfunction

    function automatic intercept_t predict_intercept(seg_pair_t s);
        intercept_t r;
        longint fax, fay, lax, lay, fbx, fby, lbx, lby, dax, day, dbx, dby;
        logic signed [127:0] den, num;
        longint ix, iy;
        fax = s.ax0; fay = s.ay0; lax = s.ax1; lay = s.ay1;
        fbx = s.bx0; fby = s.by0; lbx = s.bx1; lby = s.by1;
        dax = lax - fax; day = lay - fay;
        dbx = lbx - fbx; dby = lby - fby;
        r = '{1'b0, '0, '0, PLACE_BETWEEN, PLACE_BETWEEN, '0, '0};
        den = 128'(dax * dby - day * dbx);
        if (den == 0)
            return r;
        num = 128'((fbx - fax) * dby - (fby - fay) * dbx);
        ix = sat_wide(128'(fax) + div_round(num * 128'(dax), den));
        iy = sat_wide(128'(fay) + div_round(num * 128'(day), den));
        r.found = 1'b1;
        r.x = coord_t'(ix);
        r.y = coord_t'(iy);
        place_on(fax, fay, lax, lay, ix, iy, r.pa, r.da);
        place_on(fbx, fby, lbx, lby, ix, iy, r.pb, r.db);
        return r;
    endfunction

    function automatic coord_t rnd(int span);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t s;
        int px, py, dx, dy, ex, ey, k;
        case ($urandom_range(0, 9))
            0, 1:
                s = '{rnd(CSPAN), rnd(CSPAN), rnd(CSPAN), rnd(CSPAN),
                      rnd(CSPAN), rnd(CSPAN), rnd(CSPAN), rnd(CSPAN)};
            2, 3, 4:
                s = '{rnd(2000), rnd(2000), rnd(2000), rnd(2000),
                      rnd(2000), rnd(2000), rnd(2000), rnd(2000)};
            8:
            begin
                // parallel lines
                dx = rnd(3000); dy = rnd(3000); k = int'(rnd(4));
                s.ax0 = rnd(100000); s.ay0 = rnd(100000);
                s.ax1 = coord_t'(s.ax0 + dx); s.ay1 = coord_t'(s.ay0 + dy);
                s.bx0 = rnd(100000); s.by0 = rnd(100000);
                s.bx1 = coord_t'(s.bx0 + k * dx); s.by1 = coord_t'(s.by0 + k * dy);
            end
            9:
            begin
                // one segment shrunk to a point
                s = '{rnd(CSPAN), rnd(CSPAN), rnd(CSPAN), rnd(CSPAN),
                      rnd(CSPAN), rnd(CSPAN), rnd(CSPAN), rnd(CSPAN)};
                if ($urandom_range(0, 1))
                begin
                    s.ax1 = s.ax0; s.ay1 = s.ay0;
                end
                else
                begin
                    s.bx1 = s.bx0; s.by1 = s.by0;
                end
            end
            default:
            begin
                // lines built through a common point, which may fall on an endpoint
                px = int'(rnd(200000)); py = int'(rnd(200000));
                dx = int'(rnd(2000)); dy = int'(rnd(2000));
                ex = int'(rnd(2000)); ey = int'(rnd(2000));
                k = int'(rnd(3));
                s.ax0 = coord_t'(px - k * dx); s.ay0 = coord_t'(py - k * dy);
                k = int'(rnd(3));
                s.ax1 = coord_t'(px + k * dx); s.ay1 = coord_t'(py + k * dy);
                k = int'(rnd(3));
                s.bx0 = coord_t'(px - k * ex); s.by0 = coord_t'(py - k * ey);
                k = int'(rnd(3));
                s.bx1 = coord_t'(px + k * ex); s.by1 = coord_t'(py + k * ey);
            end
        endcase
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // driver: a request is taken at an edge where start is high and busy low
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                expected_hits.insert(expected_hits.size(), predict_intercept(in_flight));
                n_sent++;
            end
            if ((start && busy) || gap > 0)
            begin
                if (!(start && busy))
                begin
                    gap--;
                    start <= 1'b0;
                end
            end
            else if (pending.size() > 0)
            begin
                in_flight = pending.pop_front();
                a_first_x <= in_flight.ax0; a_first_y <= in_flight.ay0;
                a_last_x  <= in_flight.ax1; a_last_y  <= in_flight.ay1;
                b_first_x <= in_flight.bx0; b_first_y <= in_flight.by0;
                b_last_x  <= in_flight.bx1; b_last_y  <= in_flight.by1;
                start <= 1'b1;
                gap = pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        intercept_t e;
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b x=%0d y=%0d", found, cross_x,
                             cross_y);
            end
            else
            begin
                e = expected_hits.pop_front();
                n_checked++;
                if (e.found)
                begin
                    n_found++;
                    n_place[e.pa]++;
                    n_place[e.pb]++;
                end
                if (found !== e.found || cross_x !== e.x || cross_y !== e.y
                    || place_a !== e.pa || place_b !== e.pb
                    || path_a !== e.da || path_b !== e.db)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp f=%0b x=%0d y=%0d pa=%0d pb=%0d da=%0d db=%0d",
                                 e.found, e.x, e.y, e.pa, e.pb, e.da, e.db);
                        $display("          got f=%0b x=%0d y=%0d pa=%0d pb=%0d da=%0d db=%0d",
                                 found, cross_x, cross_y, place_a, place_b, path_a, path_b);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                            int bx0, int by0, int bx1, int by1);
        seg_pair_t s;
        s = '{coord_t'(ax0), coord_t'(ay0), coord_t'(ax1), coord_t'(ay1),
              coord_t'(bx0), coord_t'(by0), coord_t'(bx1), coord_t'(by1)};
        pending.insert(pending.size(), s);
    endtask

    initial
    begin
        int mx, mn;
        mx = int'(CMAX); mn = int'(CMIN);
        // crossing inside both segments
        add_pair(-100, 0, 100, 0, 0, -100, 0, 100);
        // before the first point and beyond the last
        add_pair(10, 0, 100, 0, -50, -100, -50, -20);
        add_pair(0, 0, 100, 100, 200, 0, 300, -100);
        // crossing exactly on a first point, then on a last point
        add_pair(0, 0, 100, 0, 0, -50, 0, 50);
        add_pair(0, 0, 100, 0, 100, 50, 100, -50);
        // rounding ties and fractional crossings
        add_pair(0, 0, 3, 1, 0, 1, 3, 0);
        add_pair(0, 0, -7, 3, 1, 2, -5, -4);
        // parallel, collinear and coincident endpoints
        add_pair(0, 0, 100, 50, 10, 0, 110, 50);
        add_pair(0, 0, 100, 50, 200, 100, 300, 150);
        add_pair(5, 5, 5, 5, 0, 0, 10, 7);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        // extremes: saturated crossing points and path lengths
        add_pair(mn, mn, mx, mx, mn, mx, mx, mn);
        add_pair(mn, 0, mx, 1, mn, 2, mx, 4);
        add_pair(mx, mx, mx - 1, mx, mn, mn, mn, mn + 1);
        add_pair(mn, mn, mn + 1, mn, mx, mx, mx, mx - 1);
        add_pair(mx, mn, mn, mx, mx, mx, mn, mn);
        add_pair(-1, -1, 1, 1, mx, mn, mx - 2, mn + 1);
        for (int i = 0; i < RANDOM_PAIRS; i++)
            pending.insert(pending.size(), random_pair());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (pending.size() > 0 || start)
            @(posedge clk);
        while (expected_hits.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d with a crossing",
                 n_sent, n_checked, n_found);
        $display("placements between/before/beyond: %0d/%0d/%0d, mismatches: %0d",
                 n_place[0], n_place[1], n_place[2], mismatches);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
